[hdl/ray_box_hit_test_top_defines.svh]
`ifndef RAY_BOX_HIT_TEST_TOP_DEFINES_SVH
`define RAY_BOX_HIT_TEST_TOP_DEFINES_SVH

// Checks an implication on every clock edge outside reset.
`define RBH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define RBH_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rbh_pkg.sv]
package rbh_pkg;

    localparam int PORT_WIDTH = 32;
    localparam int AXES       = 3;

    typedef struct packed {
        logic signed [PORT_WIDTH-1:0] origin_x;
        logic signed [PORT_WIDTH-1:0] origin_y;
        logic signed [PORT_WIDTH-1:0] origin_z;
        logic signed [PORT_WIDTH-1:0] dir_x;
        logic signed [PORT_WIDTH-1:0] dir_y;
        logic signed [PORT_WIDTH-1:0] dir_z;
        logic signed [PORT_WIDTH-1:0] box_min_x;
        logic signed [PORT_WIDTH-1:0] box_min_y;
        logic signed [PORT_WIDTH-1:0] box_min_z;
        logic signed [PORT_WIDTH-1:0] box_max_x;
        logic signed [PORT_WIDTH-1:0] box_max_y;
        logic signed [PORT_WIDTH-1:0] box_max_z;
    } query_t;

    typedef struct packed {
        logic hit;
    } result_t;

endpackage

[hdl/rbh_stream_if.sv]
interface rbh_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/rbh_front.sv]
module rbh_front
    import rbh_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    rbh_stream_if.sink                        query,
    input  logic                              push_ready,
    output logic                              push_valid,
    output logic [AXES*(5*COORD_WIDTH+5)-1:0] push_data
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = 5*W + 5;

    logic signed [W-1:0] p [AXES];
    logic signed [W-1:0] d [AXES];
    logic signed [W-1:0] bmin [AXES];
    logic signed [W-1:0] bmax [AXES];

    function automatic logic signed [W-1:0] fit(input logic signed [PORT_WIDTH-1:0] v);
        logic signed [PORT_WIDTH+W-1:0] ext;
        ext = (PORT_WIDTH+W)'(v);
        return ext[W-1:0];
    endfunction

    assign p[0]    = fit(query.payload.origin_x);
    assign p[1]    = fit(query.payload.origin_y);
    assign p[2]    = fit(query.payload.origin_z);
    assign d[0]    = fit(query.payload.dir_x);
    assign d[1]    = fit(query.payload.dir_y);
    assign d[2]    = fit(query.payload.dir_z);
    assign bmin[0] = fit(query.payload.box_min_x);
    assign bmin[1] = fit(query.payload.box_min_y);
    assign bmin[2] = fit(query.payload.box_min_z);
    assign bmax[0] = fit(query.payload.box_max_x);
    assign bmax[1] = fit(query.payload.box_max_y);
    assign bmax[2] = fit(query.payload.box_max_z);

    // per axis: the only face that can face the ray, its t = n / den, and the bound offsets
    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic signed [W:0] sp, sd, smin, smax, n, den, lo, hi;
        logic              neg, val;

        assign sp   = (W+1)'(p[a]);
        assign sd   = (W+1)'(d[a]);
        assign smin = (W+1)'(bmin[a]);
        assign smax = (W+1)'(bmax[a]);
        assign neg  = d[a][W-1];
        assign n    = neg ? (sp - smax) : (smin - sp);
        assign den  = neg ? -sd : sd;
        assign val  = (d[a] != '0) && !n[W];
        assign lo   = smin - sp;
        assign hi   = smax - sp;

        assign push_data[a*AW +: AW] = {val, n, den, lo, hi, d[a]};
    end

    assign push_valid  = query.valid;
    assign query.ready = push_ready;

endmodule

[hdl/rbh_queue.sv]
module rbh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/rbh_back.sv]
`include "ray_box_hit_test_top_defines.svh"

module rbh_back
    import rbh_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  logic [AXES*(5*COORD_WIDTH+5)-1:0] pop_data,
    rbh_stream_if.source                      result
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = 5*W + 5;
    localparam int PWD = 2*W + 2;

    logic signed [W:0]     n [AXES];
    logic signed [W:0]     den [AXES];
    logic signed [W:0]     lo [AXES];
    logic signed [W:0]     hi [AXES];
    logic signed [W:0]     dx [AXES];
    logic                  val [AXES];

    logic signed [PWD-1:0] dn_next [AXES][2];
    logic signed [PWD-1:0] lo_next [AXES][2];
    logic signed [PWD-1:0] hi_next [AXES][2];
    logic signed [PWD-1:0] dn_reg  [AXES][2];
    logic signed [PWD-1:0] lo_reg  [AXES][2];
    logic signed [PWD-1:0] hi_reg  [AXES][2];
    logic                  val_reg [AXES];
    logic                  p_v_reg, o_v_reg, o_hit_reg, hit_next;
    logic                  adv_o, adv_p, pop;

    for (genvar a = 0; a < AXES; a++) begin : g_unpack
        assign dx[a]  = (W+1)'($signed(pop_data[a*AW +: W]));
        assign hi[a]  = pop_data[a*AW + W       +: W+1];
        assign lo[a]  = pop_data[a*AW + 2*W + 1 +: W+1];
        assign den[a] = pop_data[a*AW + 3*W + 2 +: W+1];
        assign n[a]   = pop_data[a*AW + 4*W + 3 +: W+1];
        assign val[a] = pop_data[a*AW + 5*W + 4];
    end

    // cross-multiplied bounds: (lo-p)*den <= d*n <= (hi-p)*den on the two other axes
    for (genvar a = 0; a < AXES; a++) begin : g_face
        for (genvar j = 0; j < 2; j++) begin : g_side
            localparam int B = (a + 1 + j) % AXES;
            assign dn_next[a][j] = dx[B] * n[a];
            assign lo_next[a][j] = lo[B] * den[a];
            assign hi_next[a][j] = hi[B] * den[a];
        end
    end

    assign adv_o     = !o_v_reg || result.ready;
    assign adv_p     = !p_v_reg || adv_o;
    assign pop_ready = adv_p;
    assign pop       = pop_valid && adv_p;

    always_comb
    begin
        hit_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if (val_reg[a] &&
                lo_reg[a][0] <= dn_reg[a][0] && dn_reg[a][0] <= hi_reg[a][0] &&
                lo_reg[a][1] <= dn_reg[a][1] && dn_reg[a][1] <= hi_reg[a][1])
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_p)
            begin
                p_v_reg <= pop_valid;
            end
            if (adv_o)
            begin
                o_v_reg <= p_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dn_reg  <= dn_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            val_reg <= val;
        end
        if (adv_o && p_v_reg)
        begin
            o_hit_reg <= hit_next;
        end
    end

    assign result.valid       = o_v_reg;
    assign result.payload.hit = o_hit_reg;

    `RBH_ASSERT(a_pop_fills_stage, pop |=> p_v_reg, "popped transfer lost before product stage")
    `RBH_ASSERT(a_stage_holds, (p_v_reg && !adv_o) |=> p_v_reg, "product stage dropped a stalled item")
    `RBH_ASSERT(a_stage_moves, (p_v_reg && adv_o) |=> o_v_reg, "product stage result did not reach output")

endmodule

[hdl/ray_box_hit_test_top.sv]
// Ray versus axis-aligned box front-face hit test.
// query  (sink):   one transfer per ray/box pair, signed Q16.16 coordinates;
//                  only the low COORD_WIDTH bits of each field are used.
// result (source): one transfer per query, hit = 1 when the ray enters the
//                  box through a face whose normal opposes the direction.
// Both channels complete a transfer on a clock edge with valid and ready high.
// A query's result is offered once it has passed through each register in turn
// (classify into queue, product stage, compare into output register).
// Throughput: one query per cycle while result is ready; the product stage has
// 18 multipliers of (COORD_WIDTH+1) x (COORD_WIDTH+1) bits so every item flows without reuse.
// A queue of QUEUE_DEPTH entries sits between classify and product stages.
// When result is stalled, the output and product stages hold, then the queue
// fills; query.ready drops only once the queue is full.
// Reset (rst_n low, asynchronous) empties the queue and both stages; no
// result is pending afterward and query.ready is high.
module ray_box_hit_test_top
    import rbh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    rbh_stream_if.sink   query,
    rbh_stream_if.source result
);

    localparam int QW = AXES * (5*COORD_WIDTH + 5);

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [QW-1:0] push_data, pop_data;

    rbh_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .query      (query),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    rbh_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rbh_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

[sim/ray_box_hit_test_top_test.sv]
`timescale 1ns / 1ps

module ray_box_hit_test_top_test;
    import rbh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1350;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    rbh_stream_if #(.payload_t(query_t))  query_ch ();
    rbh_stream_if #(.payload_t(result_t)) result_ch ();

    ray_box_hit_test_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch.sink),
        .result (result_ch.source)
    );

    query_t  pending_queries[$];
    logic    expected_hits[$];
    bit      stimulus_done = 1'b0;
    bit      failed = 1'b0;
    bit      calm = 1'b0;
    int      hold_off = 0;
    int      idle_cycles = 0;
    int      accepted_count = 0;

    function automatic logic signed [127:0] wide_mul(longint a, longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic bit within_face(longint p, longint d, longint lo, longint hi,
                                       longint n, longint den);
        logic signed [127:0] v;
        v = wide_mul(d, n);
        return (wide_mul(lo - p, den) <= v) && (v <= wide_mul(hi - p, den));
    endfunction

    function automatic bit face_entered(longint p[3], longint d[3], longint bmin[3],
                                        longint bmax[3], int axis, bit upper);
        int     b;
        int     c;
        longint n;
        longint den;
        b = (axis + 1) % 3;
        c = (axis + 2) % 3;
        if (upper)
        begin
            if (!(d[axis] < 0))
                return 1'b0;
            n = p[axis] - bmax[axis];
            den = -d[axis];
        end
        else
        begin
            if (!(d[axis] > 0))
                return 1'b0;
            n = bmin[axis] - p[axis];
            den = d[axis];
        end
        if (n < 0)
            return 1'b0;
        return within_face(p[b], d[b], bmin[b], bmax[b], n, den) &&
               within_face(p[c], d[c], bmin[c], bmax[c], n, den);
    endfunction

    function automatic logic predict_hit(query_t q);
        longint p[3];
        longint d[3];
        longint bmin[3];
        longint bmax[3];
        p    = '{longint'(q.origin_x), longint'(q.origin_y), longint'(q.origin_z)};
        d    = '{longint'(q.dir_x), longint'(q.dir_y), longint'(q.dir_z)};
        bmin = '{longint'(q.box_min_x), longint'(q.box_min_y), longint'(q.box_min_z)};
        bmax = '{longint'(q.box_max_x), longint'(q.box_max_y), longint'(q.box_max_z)};
        return face_entered(p, d, bmin, bmax, 1, 1'b1) ||
               face_entered(p, d, bmin, bmax, 1, 1'b0) ||
               face_entered(p, d, bmin, bmax, 0, 1'b1) ||
               face_entered(p, d, bmin, bmax, 0, 1'b0) ||
               face_entered(p, d, bmin, bmax, 2, 1'b1) ||
               face_entered(p, d, bmin, bmax, 2, 1'b0);
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] coord(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span) << 16;
    endfunction

    // aim at a random point near the box so hits are common
    function automatic query_t aimed_query();
        query_t q;
        int     span;
        int     lo[3];
        int     hi[3];
        int     o[3];
        int     tgt[3];
        int     i;
        span = ($urandom_range(0, 3) == 0) ? 30000 : 40;
        for (i = 0; i < 3; i++)
        begin
            lo[i] = $urandom_range(0, span) - span / 2;
            hi[i] = lo[i] + $urandom_range(0, span / 2);
            if ($urandom_range(0, 20) == 0)
                hi[i] = lo[i] - 1;
            o[i] = $urandom_range(0, 3 * span) - 3 * span / 2;
            tgt[i] = $urandom_range(0, hi[i] - lo[i] + 2) + lo[i] - 1;
        end
        q.origin_x  = 32'(o[0]) << 16;
        q.origin_y  = 32'(o[1]) << 16;
        q.origin_z  = 32'(o[2]) << 16;
        q.dir_x     = (32'(tgt[0] - o[0]) << 16) + 32'($urandom_range(0, 3));
        q.dir_y     = (32'(tgt[1] - o[1]) << 16) + 32'($urandom_range(0, 3));
        q.dir_z     = (32'(tgt[2] - o[2]) << 16) + 32'($urandom_range(0, 3));
        q.box_min_x = 32'(lo[0]) << 16;
        q.box_min_y = 32'(lo[1]) << 16;
        q.box_min_z = 32'(lo[2]) << 16;
        q.box_max_x = 32'(hi[0]) << 16;
        q.box_max_y = 32'(hi[1]) << 16;
        q.box_max_z = 32'(hi[2]) << 16;
        if ($urandom_range(0, 5) == 0)
            q.origin_y = q.box_max_y;
        return q;
    endfunction

    function automatic query_t box_query(int ox, int oy, int oz, int dx, int dy, int dz);
        query_t q;
        q.origin_x  = coord(0) + (32'(ox) << 16);
        q.origin_y  = 32'(oy) << 16;
        q.origin_z  = 32'(oz) << 16;
        q.dir_x     = 32'(dx) << 16;
        q.dir_y     = 32'(dy) << 16;
        q.dir_z     = 32'(dz) << 16;
        q.box_min_x = 32'(-1) << 16;
        q.box_min_y = 32'(-1) << 16;
        q.box_min_z = 32'(-1) << 16;
        q.box_max_x = 32'(1) << 16;
        q.box_max_y = 32'(1) << 16;
        q.box_max_z = 32'(1) << 16;
        return q;
    endfunction

    initial
    begin
        query_t q;
        int     i;
        pending_queries.push_back(box_query(0, 5, 0, 0, -1, 0));
        pending_queries.push_back(box_query(0, -5, 0, 0, 1, 0));
        pending_queries.push_back(box_query(5, 0, 0, -1, 0, 0));
        pending_queries.push_back(box_query(-5, 0, 0, 1, 0, 0));
        pending_queries.push_back(box_query(0, 0, 5, 0, 0, -1));
        pending_queries.push_back(box_query(0, 0, -5, 0, 0, 1));
        pending_queries.push_back(box_query(0, 5, 0, 0, 0, 0));
        pending_queries.push_back(box_query(0, 0, 0, 1, 1, 1));
        pending_queries.push_back(box_query(0, 1, 0, 0, -1, 0));
        pending_queries.push_back(box_query(1, 1, 1, -1, -1, -1));
        pending_queries.push_back(box_query(0, 5, 0, 0, 1, 0));
        pending_queries.push_back(box_query(2, 5, 0, 0, -1, 0));
        pending_queries.push_back(box_query(3, 3, 0, -1, -1, 0));
        q = box_query(0, 5, 0, 0, -1, 0);
        q.box_min_x = 32'(2) << 16;
        pending_queries.push_back(q);
        q = '1;
        pending_queries.push_back(q);
        q = '0;
        pending_queries.push_back(q);
        q = {12{32'h8000_0000}};
        pending_queries.push_back(q);
        q = {12{32'h7fff_ffff}};
        pending_queries.push_back(q);
        q = box_query(0, 0, 0, 0, 0, 0);
        q.origin_y = 32'h7fff_ffff;
        q.dir_y    = 32'h8000_0000;
        q.box_min_x = 32'h8000_0000;
        q.box_max_x = 32'h7fff_ffff;
        q.box_min_z = 32'h8000_0000;
        q.box_max_z = 32'h7fff_ffff;
        q.dir_x    = 32'h7fff_ffff;
        pending_queries.push_back(q);
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                q = aimed_query();
            else
                q = {any_word(), any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word()};
            pending_queries.push_back(q);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (accepted_count > 300 && accepted_count < 700)
            calm <= 1'b1;
        else
            calm <= 1'b0;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_ch.valid   <= 1'b0;
            query_ch.payload <= '0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
            begin
                expected_hits.push_back(predict_hit(query_ch.payload));
                accepted_count <= accepted_count + 1;
            end
            if (!query_ch.valid || query_ch.ready)
            begin
                if (pending_queries.size() > 0 && (calm || $urandom_range(0, 99) >= 26))
                begin
                    query_ch.valid   <= 1'b1;
                    query_ch.payload <= pending_queries.pop_front();
                end
                else
                    query_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_off        <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit: unexpected transfer, actual %0b", result_ch.payload.hit);
                    failed = 1'b1;
                end
                else if (expected_hits[0] !== result_ch.payload.hit)
                begin
                    $error("hit: expected %0b, actual %0b", expected_hits[0],
                           result_ch.payload.hit);
                    failed = 1'b1;
                    void'(expected_hits.pop_front());
                end
                else
                    void'(expected_hits.pop_front());
            end
            if (accepted_count == 100 && hold_off == 0)
                hold_off <= 60;
            else if (hold_off > 1)
                hold_off <= hold_off - 1;
            if (hold_off > 1 || (accepted_count == 100 && hold_off == 0))
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= calm || $urandom_range(0, 99) >= 26;
        end
    end

    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** ray_box_hit_test_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done);
        @(negedge clk);
        while (pending_queries.size() > 0 || query_ch.valid || expected_hits.size() > 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (!failed && expected_hits.size() == 0)
            $display("** ray_box_hit_test_top: PASSED **");
        else
            $display("** ray_box_hit_test_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/rbh_pkg.sv
hdl/rbh_stream_if.sv
hdl/rbh_front.sv
hdl/rbh_queue.sv
hdl/rbh_back.sv
hdl/ray_box_hit_test_top.sv
sim/ray_box_hit_test_top_test.sv
